>>> design/bal_pkg.sv
// package for the bump allocator: pool geometry, codes, state type and structs
// used by the controller and the top level
`timescale 1ns / 1ps

package bal_pkg;

    // pool geometry
    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int POS_W        = ADDR_W + 1;
    localparam int FIELD_W      = 13;
    localparam int HDR_W        = 8 * HEADER_BYTES;
    localparam int SUM_W        = ((HDR_W > POS_W) ? HDR_W : POS_W) + 2;

    // operation codes
    localparam logic [2:0] FUNC_ALLOC   = 3'd0;
    localparam logic [2:0] FUNC_REALLOC = 3'd1;
    localparam logic [2:0] FUNC_FREE    = 3'd2;
    localparam logic [2:0] FUNC_WRITE   = 3'd3;
    localparam logic [2:0] FUNC_READ    = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BAD      = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_HDR_RD,
        S_CHECK,
        S_HDR_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_ZERO,
        S_BYTE_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic [FIELD_W-1:0] handle;
        logic [FIELD_W-1:0] size;
        logic [11:0]        pool_address;
        logic [7:0]         write_byte;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] block_handle;
        logic [7:0]         read_byte;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

>>> design/bal_if.sv
// valid/ready channel interfaces for the bump allocator command and result items
// standalone, no package dependency
`timescale 1ns / 1ps

interface bal_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [12:0] handle;
    logic [12:0] size;
    logic [11:0] pool_address;
    logic [7:0]  write_byte;

    modport source (output valid, func, handle, size, pool_address, write_byte,
                    input ready);
    modport sink   (input valid, func, handle, size, pool_address, write_byte,
                    output ready);
endinterface

interface bal_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [12:0] block_handle;
    logic [7:0]  read_byte;

    modport source (output valid, status, block_handle, read_byte, input ready);
    modport sink   (input valid, status, block_handle, read_byte, output ready);
endinterface

>>> design/bal_pool_ram.sv
// generic simple dual port ram: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module bal_pool_ram #(
    parameter int  DEPTH = 4096,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bal_ctrl.sv
// sequencer of the bump allocator: clearing pass, header read and write,
// copy and zero walks over the pool memory; depends on bal_pkg
`timescale 1ns / 1ps

module bal_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bal_pkg::t_cmd   i_cmd,
    output logic            o_ready,
    output logic            o_done,
    output bal_pkg::t_res   o_res,
    input  logic            i_take,
    output bal_pkg::t_mem_req o_mem,
    input  logic [7:0]      i_rdata
);
    import bal_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [POS_W-1:0]   r_cnt;
    logic [POS_W-1:0]   r_top;
    t_cmd               r_cmd;
    t_res               r_res;
    logic [HDR_W-1:0]   r_hdr;
    logic [HDR_W-1:0]   r_hdr_val;
    logic [POS_W-1:0]   r_hdr_at;
    logic [POS_W-1:0]   r_src;
    logic [POS_W-1:0]   r_dst;
    logic [POS_W-1:0]   r_len;
    logic               r_copy;

    logic [SUM_W-1:0]   w_alloc_end;
    logic               w_alloc_fit;
    logic [SUM_W-1:0]   w_blk_end;
    logic               w_blk_ok;
    logic               w_is_top;
    logic [SUM_W-1:0]   w_resize_end;
    logic               w_resize_fit;
    logic               w_in_range;
    logic               w_addr_ok;
    logic               w_cnt_last;
    logic [POS_W-1:0]   w_hdr_rd_pos;
    logic [POS_W-1:0]   w_hdr_wr_pos;
    logic [HDR_W-1:0]   w_hdr_shift;
    logic [POS_W-1:0]   w_min_len;
    logic [POS_W-1:0]   w_hb_idx;

    // offset arithmetic
    assign w_alloc_end  = SUM_W'(r_top) + SUM_W'(HEADER_BYTES) + SUM_W'(r_cmd.size);
    assign w_alloc_fit  = w_alloc_end <= SUM_W'(POOL_BYTES);
    assign w_blk_end    = SUM_W'(r_cmd.handle) + SUM_W'(r_hdr);
    assign w_blk_ok     = w_blk_end <= SUM_W'(r_top);
    assign w_is_top     = w_blk_end == SUM_W'(r_top);
    assign w_resize_end = SUM_W'(r_cmd.handle) + SUM_W'(r_cmd.size);
    assign w_resize_fit = w_resize_end <= SUM_W'(POOL_BYTES);
    assign w_in_range   = (SUM_W'(r_cmd.handle) >= SUM_W'(HEADER_BYTES))
                       && (SUM_W'(r_cmd.handle) <= SUM_W'(r_top));
    assign w_addr_ok    = 32'(r_cmd.pool_address) < POOL_BYTES;
    assign w_cnt_last   = (r_cnt + POS_W'(1)) == r_len;
    assign w_hdr_rd_pos = POS_W'(r_cmd.handle) - POS_W'(HEADER_BYTES) + r_cnt;
    assign w_hdr_wr_pos = r_hdr_at + r_cnt;
    assign w_hdr_shift  = r_hdr_val >> {r_cnt, 3'b000};
    assign w_min_len    = (SUM_W'(r_hdr) < SUM_W'(r_cmd.size)) ? POS_W'(r_hdr)
                                                              : POS_W'(r_cmd.size);
    assign w_hb_idx     = r_cnt - POS_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == POS_W'(POOL_BYTES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_cmd.func)
                    FUNC_ALLOC:   n_state = w_alloc_fit ? S_HDR_WR : S_DONE;
                    FUNC_REALLOC,
                    FUNC_FREE: begin
                        if (r_cmd.handle != '0 && w_in_range) n_state = S_HDR_RD;
                        else                                  n_state = S_DONE;
                    end
                    FUNC_READ:    n_state = w_addr_ok ? S_BYTE_RD : S_DONE;
                    default:      n_state = S_DONE;
                endcase
            end
            S_HDR_RD: begin
                if (r_cnt == POS_W'(HEADER_BYTES)) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_blk_ok) begin
                    n_state = S_DONE;
                end else if (r_cmd.func == FUNC_REALLOC) begin
                    if (w_is_top) n_state = w_resize_fit ? S_HDR_WR : S_DONE;
                    else          n_state = w_alloc_fit ? S_HDR_WR : S_DONE;
                end else begin
                    n_state = (r_hdr == '0) ? S_DONE : S_ZERO;
                end
            end
            S_HDR_WR: begin
                if (r_cnt == POS_W'(HEADER_BYTES - 1)) begin
                    n_state = (r_copy && r_len != '0) ? S_COPY_RD : S_DONE;
                end
            end
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: n_state = w_cnt_last ? S_DONE : S_COPY_RD;
            S_ZERO:    n_state = w_cnt_last ? S_DONE : S_ZERO;
            S_BYTE_RD: n_state = S_DONE;
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        o_mem       = '0;
        o_mem.raddr = ADDR_W'(r_cmd.pool_address);
        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(r_cnt);
            end
            S_DECODE: begin
                o_mem.we    = (r_cmd.func == FUNC_WRITE) && w_addr_ok;
                o_mem.waddr = ADDR_W'(r_cmd.pool_address);
                o_mem.wdata = r_cmd.write_byte;
            end
            S_HDR_RD: begin
                o_mem.raddr = ADDR_W'(w_hdr_rd_pos);
            end
            S_HDR_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(w_hdr_wr_pos);
                o_mem.wdata = w_hdr_shift[7:0];
            end
            S_COPY_RD: begin
                o_mem.raddr = ADDR_W'(r_src + r_cnt);
            end
            S_COPY_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(r_dst + r_cnt);
                o_mem.wdata = i_rdata;
            end
            S_ZERO: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(r_dst + r_cnt);
            end
            default: begin
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_res   = r_res;

    // control registers: state, walk counter, top of pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= (n_state == S_IDLE) ? '0 : r_cnt + POS_W'(1);
                end
                S_IDLE: begin
                    r_cnt <= '0;
                end
                S_DECODE: begin
                    if (r_cmd.func == FUNC_ALLOC && w_alloc_fit) begin
                        r_top <= POS_W'(w_alloc_end);
                    end
                end
                S_HDR_RD: begin
                    r_cnt <= (n_state == S_CHECK) ? '0 : r_cnt + POS_W'(1);
                end
                S_CHECK: begin
                    if (w_blk_ok) begin
                        if (r_cmd.func == FUNC_REALLOC) begin
                            if (w_is_top) begin
                                if (w_resize_fit) r_top <= POS_W'(w_resize_end);
                            end else if (w_alloc_fit) begin
                                r_top <= POS_W'(w_alloc_end);
                            end
                        end else if (w_is_top) begin
                            r_top <= r_top - POS_W'(r_hdr) - POS_W'(HEADER_BYTES);
                        end
                    end
                end
                S_HDR_WR: begin
                    r_cnt <= (r_cnt == POS_W'(HEADER_BYTES - 1)) ? '0 : r_cnt + POS_W'(1);
                end
                S_COPY_WR,
                S_ZERO: begin
                    r_cnt <= r_cnt + POS_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // item payload and walk bounds
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_cmd  <= i_cmd;
                    r_res  <= '0;
                    r_copy <= 1'b0;
                end
            end
            S_DECODE: begin
                case (r_cmd.func)
                    FUNC_ALLOC: begin
                        if (w_alloc_fit) begin
                            r_hdr_at           <= r_top;
                            r_hdr_val          <= HDR_W'(r_cmd.size);
                            r_res.block_handle <= FIELD_W'(r_top + POS_W'(HEADER_BYTES));
                        end else begin
                            r_res.status <= STATUS_NO_SPACE;
                        end
                    end
                    FUNC_REALLOC: begin
                        if (r_cmd.handle == '0 || !w_in_range) r_res.status <= STATUS_BAD;
                    end
                    FUNC_FREE: begin
                        if (r_cmd.handle != '0 && !w_in_range) r_res.status <= STATUS_BAD;
                    end
                    FUNC_WRITE,
                    FUNC_READ: begin
                        if (!w_addr_ok) r_res.status <= STATUS_BAD;
                    end
                    default: r_res.status <= STATUS_BAD;
                endcase
            end
            S_HDR_RD: begin
                // header bytes arrive in the cycle after their address, lsb first
                if (r_cnt != '0) r_hdr[w_hb_idx * 8 +: 8] <= i_rdata;
            end
            S_CHECK: begin
                if (!w_blk_ok) begin
                    r_res.status <= STATUS_BAD;
                end else if (r_cmd.func == FUNC_REALLOC) begin
                    r_hdr_val <= HDR_W'(r_cmd.size);
                    if (w_is_top) begin
                        // resize in place
                        if (w_resize_fit) begin
                            r_hdr_at           <= POS_W'(r_cmd.handle)
                                                - POS_W'(HEADER_BYTES);
                            r_res.block_handle <= r_cmd.handle;
                        end else begin
                            r_res.status <= STATUS_NO_SPACE;
                        end
                    end else if (w_alloc_fit) begin
                        // move to a new top block
                        r_hdr_at           <= r_top;
                        r_res.block_handle <= FIELD_W'(r_top + POS_W'(HEADER_BYTES));
                        r_src              <= POS_W'(r_cmd.handle);
                        r_dst              <= r_top + POS_W'(HEADER_BYTES);
                        r_len              <= w_min_len;
                        r_copy             <= 1'b1;
                    end else begin
                        r_res.status <= STATUS_NO_SPACE;
                    end
                end else begin
                    // free: zero the block body
                    r_dst <= POS_W'(r_cmd.handle);
                    r_len <= POS_W'(r_hdr);
                end
            end
            S_BYTE_RD: begin
                r_res.read_byte <= i_rdata;
            end
            default: begin
            end
        endcase
    end

    // top never passes the pool end
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_top) <= SUM_W'(POOL_BYTES))
        else $error("top offset beyond pool end");

    // an accepted item goes straight to decode
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && o_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    // copy destination stays below the new top
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY_WR) |-> (SUM_W'(r_dst) + SUM_W'(r_cnt) < SUM_W'(r_top)))
        else $error("copy writes past top");

    // a finished result is held until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_take) |=> (o_done && $stable(r_res)))
        else $error("result dropped before taken");

endmodule

>>> design/bump_allocator_with_size_headers_unit.sv
// Bump allocator over a 4096-byte pool with 4-byte little-endian size headers.
// After reset the block clears the pool, one byte per cycle, and takes no item
// until that pass ends. Every item is then handled one at a time through the
// single byte-wide pool memory: alloc writes four header bytes; realloc and free
// read the header byte by byte and then check it, then realloc writes the header
// and, when the block moves, copies each byte with a read and then a write, while
// free zeroes the block body byte by byte. A result sits in an output register,
// so the next item is accepted while it waits to be taken.
// depends on bal_pkg, bal_if, bal_pool_ram and bal_ctrl
`timescale 1ns / 1ps

module bump_allocator_with_size_headers_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bal_cmd_if.sink   i_cmd,
    bal_res_if.source o_res
);
    import bal_pkg::*;

    t_cmd      w_cmd;
    t_res      w_res;
    t_mem_req  w_mem;
    logic [7:0] w_rdata;
    logic      w_ready;
    logic      w_done;
    logic      w_take;
    logic      r_res_valid;
    t_res      r_res;

    // command payload into one struct
    always_comb begin
        w_cmd.func         = i_cmd.func;
        w_cmd.handle       = i_cmd.handle;
        w_cmd.size         = i_cmd.size;
        w_cmd.pool_address = i_cmd.pool_address;
        w_cmd.write_byte   = i_cmd.write_byte;
    end

    assign i_cmd.ready = w_ready;

    bal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.valid),
        .i_cmd   (w_cmd),
        .o_ready (w_ready),
        .o_done  (w_done),
        .o_res   (w_res),
        .i_take  (w_take),
        .o_mem   (w_mem),
        .i_rdata (w_rdata)
    );

    bal_pool_ram #(
        .DEPTH (POOL_BYTES),
        .WIDTH (8)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // output register takes a result when empty or being drained
    assign w_take = w_done && (!r_res_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_take) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.status       = r_res.status;
    assign o_res.block_handle = r_res.block_handle;
    assign o_res.read_byte    = r_res.read_byte;

endmodule
